// ===== design/ssc_pkg.sv =====
`timescale 1ns / 1ps

package ssc_pkg;

	localparam int MAX_VALUE_DEF = 1024;
	localparam int TARGET_W      = 11;
	localparam int COUNT_W       = 11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_item;
		logic push;
		logic read;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic push_more;
		logic failed;
		logic slot_free;
	} status_t;

endpackage

// ===== design/ssc_datapath.sv =====
`timescale 1ns / 1ps

module ssc_datapath #(
	parameter int MAX_VALUE = ssc_pkg::MAX_VALUE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ssc_pkg::TARGET_W-1:0] target_value,
	input  ssc_pkg::cmd_t                cmd,
	output ssc_pkg::status_t             status,
	input  logic                         result_stall,
	output logic                         result_valid,
	output logic [ssc_pkg::COUNT_W-1:0]  push_count,
	output logic                         pop_done,
	output logic                         sequence_failed
);
	import ssc_pkg::*;

	// Value width holds MAX_VALUE + 1, depth width holds MAX_VALUE.
	localparam int VW = $clog2(MAX_VALUE + 2);
	localparam int DW = $clog2(MAX_VALUE + 1);
	localparam int AW = $clog2(MAX_VALUE);
	localparam int CW = (TARGET_W > VW) ? TARGET_W : VW;

	logic [VW-1:0]       mem [MAX_VALUE];
	logic [VW-1:0]       rd_q;
	logic [TARGET_W-1:0] target_q;
	logic [VW-1:0]       limit_q;
	logic [VW-1:0]       next_q;
	logic [DW-1:0]       depth_q;
	logic [COUNT_W-1:0]  pushes_q;
	logic                failed_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  push_count_q;
	logic                pop_done_q;
	logic                seq_failed_q;

	logic [CW-1:0]       tgt_ext;
	logic [CW-1:0]       max_ext;
	logic [VW-1:0]       limit_d;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic [DW-1:0]       depth_dec;
	logic                hit;

	assign tgt_ext   = CW'(target_value);
	assign max_ext   = CW'(MAX_VALUE);
	assign limit_d   = (tgt_ext > max_ext) ? max_ext[VW-1:0] : tgt_ext[VW-1:0];
	assign depth_dec = depth_q - DW'(1);
	assign wr_addr   = depth_q[AW-1:0];
	assign rd_addr   = depth_dec[AW-1:0];
	assign hit       = (depth_q != '0) && (CW'(rd_q) == CW'(target_q));

	assign status.push_more = (next_q <= limit_q) && (depth_q < DW'(MAX_VALUE));
	assign status.failed    = failed_q;
	assign status.slot_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= next_q;
		end
		if (cmd.read) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			target_q <= target_value;
			limit_q  <= limit_d;
			pushes_q <= '0;
		end else if (cmd.push) begin
			pushes_q <= pushes_q + COUNT_W'(1);
		end
		if (cmd.finish) begin
			if (failed_q) begin
				push_count_q <= '0;
				pop_done_q   <= 1'b0;
				seq_failed_q <= 1'b1;
			end else begin
				push_count_q <= pushes_q;
				pop_done_q   <= hit;
				seq_failed_q <= !hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			next_q      <= VW'(1);
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				depth_q <= depth_q + DW'(1);
				next_q  <= next_q + VW'(1);
			end else if (cmd.finish && !failed_q) begin
				if (hit) begin
					depth_q <= depth_dec;
				end else begin
					failed_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid    = out_valid_q;
	assign push_count      = push_count_q;
	assign pop_done        = pop_done_q;
	assign sequence_failed = seq_failed_q;

endmodule

// ===== design/ssc_controller.sv =====
`timescale 1ns / 1ps

module ssc_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             target_valid,
	output logic             target_stall,
	input  ssc_pkg::status_t status,
	output ssc_pkg::cmd_t    cmd
);
	import ssc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		target_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				target_stall = 1'b0;
				if (target_valid) begin
					cmd.load_item = 1'b1;
					// After a failure no pushes happen; go straight to the result.
					state_d = status.failed ? ST_FINISH : ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (status.push_more) begin
					cmd.push = 1'b1;
				end else begin
					cmd.read = 1'b1;
					state_d  = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/stack_sequence_checker_top.sv =====
`timescale 1ns / 1ps

// Stack sequence checker: each transfer on the target channel names the next value to pop
// from a stack fed 1, 2, 3, ... in order; the block pushes every pending value up to it,
// pops the top if it matches and returns one result with the push count, the pop flag and
// a sticky failure flag (once set, later items return zero pushes and no pop). An item is
// handled in steps: accept it, push each pending value into the single-port stack memory,
// read the top of stack, then compare and load the output register once the output slot
// is free; after a failure the pushes and the read are skipped. Each value is pushed only
// once. No new item is taken until the last is compared, yet the next one is accepted
// while a result waits in the output register. No clearing pass is needed after reset.
module stack_sequence_checker_top #(
	parameter int MAX_VALUE = ssc_pkg::MAX_VALUE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         target_valid,
	output logic                         target_stall,
	input  logic [ssc_pkg::TARGET_W-1:0] target_value,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [ssc_pkg::COUNT_W-1:0]  push_count,
	output logic                         pop_done,
	output logic                         sequence_failed
);
	import ssc_pkg::*;

	cmd_t    cmd;
	status_t status;

	ssc_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.target_valid (target_valid),
		.target_stall (target_stall),
		.status       (status),
		.cmd          (cmd)
	);

	ssc_datapath #(
		.MAX_VALUE (MAX_VALUE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.target_value    (target_value),
		.cmd             (cmd),
		.status          (status),
		.result_stall    (result_stall),
		.result_valid    (result_valid),
		.push_count      (push_count),
		.pop_done        (pop_done),
		.sequence_failed (sequence_failed)
	);

endmodule
